// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the line rasterizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/clr_pkg.sv =====
// Types, constants and widths shared by the line rasterizer modules.
package clr_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int SPAN_W      = COORD_WIDTH + 1;
	localparam int ERR_W       = COORD_WIDTH + 4;
	localparam int CLIP_W      = 15;
	localparam int CMP_W       = ((COORD_WIDTH > CLIP_W) ? COORD_WIDTH : CLIP_W) + 1;
	localparam int COLOR_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_BITS     = 4 * COORD_WIDTH + 3 * COLOR_W;
	localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 2 * COORD_WIDTH + 3 * COLOR_W;
	localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP_LEFT   = 2'd0,
		REG_CLIP_RIGHT  = 2'd1,
		REG_CLIP_TOP    = 2'd2,
		REG_CLIP_BOTTOM = 2'd3
	} cfg_reg_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [SPAN_W-1:0] span_t;
	typedef logic [CLIP_W-1:0] clip_t;

	typedef struct packed {
		logic ymaj;
		logic yneg;
		logic xneg;
	} dir_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} color_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		span_t  span_major;
		span_t  span_minor;
		dir_t   dir;
		color_t color;
	} line_setup_t;

	typedef struct packed {
		logic   active;
		logic   last;
		coord_t x;
		coord_t y;
		color_t color;
	} walk_status_t;

endpackage

// ===== rtl/clipped_line_rasterizer_core.sv =====
// Top level of the clipped line rasterizer: stream ports, input and result registers.
// Order: a step transaction is captured in the input register when accepted; its
// pixel is loaded into the result register once that has room, and shown from there.
// Throughput: one transaction per cycle, start or step, but a step stalls behind a full,
// unaccepted result register. The walk's Bresenham update is an add, compare, subtract.
// Reset: arst_n clears the line, both registers' valid flags and the clip
// rectangle (left = right = top = bottom = 0).
`include "assert_macros.svh"

module clipped_line_rasterizer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// Slave stream: tdata = start_x, start_y, end_x, end_y, red, green, blue
	// (lowest bits first); tuser = opcode.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [clr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                               s_axis_tuser,
	// Master stream: tdata = pixel_x, pixel_y, out_red, out_green, out_blue
	// (lowest bits first); tuser = visible; tlast = last_pixel.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [clr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tuser,
	output logic                               m_axis_tlast,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [clr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [clr_pkg::CLIP_W-1:0]         cfg_data
);
	import clr_pkg::*;

	// Input register.
	logic                 s1_valid_q;
	opcode_t              s1_op_q;
	logic [IN_BITS-1:0]   s1_data_q;

	// Result register.
	logic                 m_valid_q;
	logic [OUT_BITS-1:0]  m_data_q;
	logic                 m_vis_q;
	logic                 m_last_q;

	coord_t       x1, y1, x2, y2;
	color_t       color_in;
	line_setup_t  setup;
	walk_status_t status;
	logic         visible;
	logic         out_free;
	logic         s1_emits;
	logic         s1_go;
	logic         load;
	logic         step;

	// Unpack the captured transaction.
	assign x1             = s1_data_q[0*COORD_WIDTH +: COORD_WIDTH];
	assign y1             = s1_data_q[1*COORD_WIDTH +: COORD_WIDTH];
	assign x2             = s1_data_q[2*COORD_WIDTH +: COORD_WIDTH];
	assign y2             = s1_data_q[3*COORD_WIDTH +: COORD_WIDTH];
	assign color_in.red   = s1_data_q[4*COORD_WIDTH +: COLOR_W];
	assign color_in.green = s1_data_q[4*COORD_WIDTH + COLOR_W +: COLOR_W];
	assign color_in.blue  = s1_data_q[4*COORD_WIDTH + 2*COLOR_W +: COLOR_W];

	// A step with an active line produces a pixel and needs room in the result
	// register; a start, or a step with no line, retires without output.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s1_emits      = s1_valid_q && (s1_op_q == OP_STEP) && status.active;
	assign s1_go         = s1_valid_q && (!s1_emits || out_free);
	assign load          = s1_go && (s1_op_q == OP_START);
	assign step          = s1_go && s1_emits;
	assign s_axis_tready = !s1_valid_q || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			s1_op_q   <= opcode_t'(s_axis_tuser);
			s1_data_q <= s_axis_tdata[IN_BITS-1:0];
		end
	end

	clr_setup u_setup (
		.x1    (x1),
		.y1    (y1),
		.x2    (x2),
		.y2    (y2),
		.color (color_in),
		.setup (setup)
	);

	clr_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.step   (step),
		.setup  (setup),
		.status (status)
	);

	clr_clip u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.x         (status.x),
		.y         (status.y),
		.visible   (visible)
	);

	// Result register: loads the current pixel of the walk as the walk advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_data_q <= {status.color.blue, status.color.green, status.color.red,
			             status.y, status.x};
			m_vis_q  <= visible;
			m_last_q <= status.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(m_data_q);
	assign m_axis_tuser  = m_vis_q;
	assign m_axis_tlast  = m_last_q;

	// Emitting the endpoint pixel ends the line.
	`ASSERT_NEXT(a_last_ends_line, clk, arst_n, step && status.last, !status.active)
	// A new result only ever follows a walk step.
	`ASSERT_IMPLIES(a_result_from_step, clk, arst_n, $rose(m_valid_q), $past(step))
	// The input side stalls only behind a full, unaccepted result register.
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !s_axis_tready, m_valid_q && !m_axis_tready)

endmodule

// ===== rtl/clr_setup.sv =====
// Line setup: spans, walk directions and major axis from two endpoints.
module clr_setup (
	input  clr_pkg::coord_t      x1,
	input  clr_pkg::coord_t      y1,
	input  clr_pkg::coord_t      x2,
	input  clr_pkg::coord_t      y2,
	input  clr_pkg::color_t      color,
	output clr_pkg::line_setup_t setup
);
	import clr_pkg::*;

	logic signed [SPAN_W-1:0] dx;
	logic signed [SPAN_W-1:0] dy;
	span_t adx;
	span_t ady;
	logic  xneg;
	logic  yneg;
	logic  ymaj;

	// Differences are one bit wider than a coordinate, so they never overflow.
	assign dx   = $signed({x1[COORD_WIDTH-1], x1}) - $signed({x2[COORD_WIDTH-1], x2});
	assign dy   = $signed({y1[COORD_WIDTH-1], y1}) - $signed({y2[COORD_WIDTH-1], y2});
	assign adx  = dx[SPAN_W-1] ? span_t'(-dx) : span_t'(dx);
	assign ady  = dy[SPAN_W-1] ? span_t'(-dy) : span_t'(dy);
	assign xneg = !(x2 > x1);
	assign yneg = !(y2 > y1);
	assign ymaj = adx < ady;

	always_comb begin
		setup            = '0;
		setup.x          = x1;
		setup.y          = y1;
		setup.span_major = ymaj ? ady : adx;
		setup.span_minor = ymaj ? adx : ady;
		setup.dir.xneg   = xneg;
		setup.dir.yneg   = yneg;
		setup.dir.ymaj   = ymaj;
		setup.color      = color;
	end

endmodule

// ===== rtl/clr_walk.sv =====
// Bresenham walk state and its combinational step update logic.
`include "assert_macros.svh"

module clr_walk (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  step,
	input  clr_pkg::line_setup_t  setup,
	output clr_pkg::walk_status_t status
);
	import clr_pkg::*;

	logic             active_q;
	coord_t           x_q;
	coord_t           y_q;
	span_t            major_q;
	span_t            minor_q;
	logic [ERR_W-1:0] err_q;
	span_t            steps_q;
	dir_t             dir_q;
	color_t           color_q;

	logic [ERR_W-1:0] twice_major;
	logic [ERR_W-1:0] err_sum;
	logic [ERR_W-1:0] err_next;
	logic             minor_pos;
	logic             take_minor;
	logic             move_x;
	logic             move_y;
	logic             last;
	coord_t           x_next;
	coord_t           y_next;

	assign twice_major = ERR_W'({major_q, 1'b0});
	assign err_sum     = err_q + ERR_W'({minor_q, 1'b0});
	assign minor_pos   = dir_q.ymaj ? !dir_q.xneg : !dir_q.yneg;
	assign take_minor  = (err_sum > twice_major) || (minor_pos && (err_sum == twice_major));
	assign err_next    = take_minor ? (err_sum - twice_major) : err_sum;
	assign move_x      = !dir_q.ymaj || take_minor;
	assign move_y      = dir_q.ymaj || take_minor;
	assign last        = (steps_q == '0);

	always_comb begin
		x_next = x_q;
		y_next = y_q;
		if (move_x) begin
			x_next = dir_q.xneg ? (x_q - COORD_WIDTH'(1)) : (x_q + COORD_WIDTH'(1));
		end
		if (move_y) begin
			y_next = dir_q.yneg ? (y_q - COORD_WIDTH'(1)) : (y_q + COORD_WIDTH'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (step && last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q     <= setup.x;
			y_q     <= setup.y;
			major_q <= setup.span_major;
			minor_q <= setup.span_minor;
			err_q   <= ERR_W'(setup.span_major);
			steps_q <= setup.span_major;
			dir_q   <= setup.dir;
			color_q <= setup.color;
		end else if (step && !last) begin
			x_q     <= x_next;
			y_q     <= y_next;
			err_q   <= err_next;
			steps_q <= steps_q - SPAN_W'(1);
		end
	end

	always_comb begin
		status        = '0;
		status.active = active_q;
		status.last   = last;
		status.x      = x_q;
		status.y      = y_q;
		status.color  = color_q;
	end

	// The error term stays within twice the major span for a whole line.
	`ASSERT_IMPLIES(a_err_bounded, clk, arst_n, active_q, err_q <= twice_major)
	`ASSERT_NEXT(a_load_activates, clk, arst_n, load, active_q)

endmodule

// ===== rtl/clr_clip.sv =====
// Clip rectangle registers and the inclusive point-in-rectangle test.
module clr_clip (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [clr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clr_pkg::CLIP_W-1:0]     cfg_data,
	input  clr_pkg::coord_t                x,
	input  clr_pkg::coord_t                y,
	output logic                           visible
);
	import clr_pkg::*;

	clip_t left_q;
	clip_t right_q;
	clip_t top_q;
	clip_t bottom_q;

	logic signed [CMP_W-1:0] xe;
	logic signed [CMP_W-1:0] ye;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CLIP_LEFT:   left_q   <= cfg_data;
				REG_CLIP_RIGHT:  right_q  <= cfg_data;
				REG_CLIP_TOP:    top_q    <= cfg_data;
				REG_CLIP_BOTTOM: bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Coordinates are sign-extended, bounds zero-extended, so negative
	// positions always fall outside.
	assign xe = $signed({{(CMP_W-COORD_WIDTH){x[COORD_WIDTH-1]}}, x});
	assign ye = $signed({{(CMP_W-COORD_WIDTH){y[COORD_WIDTH-1]}}, y});

	assign visible = (xe >= $signed({{(CMP_W-CLIP_W){1'b0}}, left_q}))
	              && (xe <= $signed({{(CMP_W-CLIP_W){1'b0}}, right_q}))
	              && (ye >= $signed({{(CMP_W-CLIP_W){1'b0}}, top_q}))
	              && (ye <= $signed({{(CMP_W-CLIP_W){1'b0}}, bottom_q}));

endmodule

// ===== verif/clipped_line_rasterizer_core_checker.sv =====
// Pixel predictor and scoreboard for the clipped line rasterizer core.
`timescale 1ns / 1ps

module clipped_line_rasterizer_core_checker
	import clr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tuser,
	input  logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CLIP_W-1:0]     cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int CW = COORD_WIDTH;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   visible;
		color_t color;
		logic   last;
	} pixel_t;

	pixel_t pending_pixels[$];

	// Shadow of the walk state and the clip rectangle.
	logic             line_on;
	coord_t           pos_x, pos_y;
	span_t            major_len, minor_len, pixels_left;
	logic [ERR_W-1:0] err_acc;
	dir_t             walk_dir;
	color_t           line_rgb;
	clip_t            clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;

	function automatic int line_span(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
		int dx, dy;
		dx = int'(x1) - int'(x0);
		dy = int'(y1) - int'(y0);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return (dx >= dy) ? dx : dy;
	endfunction

	function automatic void load_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
			color_t rgb);
		int adx, ady;
		adx = (x1 >= x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
		ady = (y1 >= y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
		walk_dir.xneg = !(x1 > x0);
		walk_dir.yneg = !(y1 > y0);
		walk_dir.ymaj = (adx < ady);
		major_len = span_t'(walk_dir.ymaj ? ady : adx);
		minor_len = span_t'(walk_dir.ymaj ? adx : ady);
		pos_x = x0;
		pos_y = y0;
		err_acc = ERR_W'(major_len);
		pixels_left = major_len;
		line_rgb = rgb;
		line_on = 1'b1;
	endfunction

	// Returns the current pixel, then moves the walk one pixel on, or ends the line after its last pixel.
	function automatic pixel_t emit_pixel();
		pixel_t p;
		logic [ERR_W-1:0] twice_major;
		logic minor_up;
		p.x = pos_x;
		p.y = pos_y;
		p.visible = int'(pos_x) >= int'(clip_left_q) && int'(pos_x) <= int'(clip_right_q) &&
			int'(pos_y) >= int'(clip_top_q) && int'(pos_y) <= int'(clip_bottom_q);
		p.color = line_rgb;
		p.last = (pixels_left == 0);
		if (p.last) begin
			line_on = 1'b0;
		end else begin
			twice_major = ERR_W'(major_len) << 1;
			minor_up = walk_dir.ymaj ? !walk_dir.xneg : !walk_dir.yneg;
			if (walk_dir.ymaj) pos_y = pos_y + (walk_dir.yneg ? -1 : 1);
			else pos_x = pos_x + (walk_dir.xneg ? -1 : 1);
			err_acc = err_acc + (ERR_W'(minor_len) << 1);
			// Ties go to the minor step only when the minor axis counts up.
			if (err_acc > twice_major || (minor_up && err_acc == twice_major)) begin
				if (walk_dir.ymaj) pos_x = pos_x + (walk_dir.xneg ? -1 : 1);
				else pos_y = pos_y + (walk_dir.yneg ? -1 : 1);
				err_acc = err_acc - twice_major;
			end
			pixels_left = pixels_left - 1'b1;
		end
		return p;
	endfunction

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: pixel %s mismatch, expected %0d, actual %0d",
				$time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			pending_pixels.delete();
			line_on = 1'b0;
			pos_x = '0;
			pos_y = '0;
			major_len = '0;
			minor_len = '0;
			pixels_left = '0;
			err_acc = '0;
			walk_dir = '0;
			line_rgb = '0;
			clip_left_q = '0;
			clip_right_q = '0;
			clip_top_q = '0;
			clip_bottom_q = '0;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: pixel mismatch, expected none, actual x=%0d y=%0d",
						$time, $signed(m_axis_tdata[CW-1:0]),
						$signed(m_axis_tdata[2*CW-1:CW]));
				end else begin
					want = pending_pixels.pop_front();
					check_field("x", want.x, $signed(m_axis_tdata[CW-1:0]));
					check_field("y", want.y, $signed(m_axis_tdata[2*CW-1:CW]));
					check_field("red", want.color.red, m_axis_tdata[2*CW+7:2*CW]);
					check_field("green", want.color.green, m_axis_tdata[2*CW+15:2*CW+8]);
					check_field("blue", want.color.blue, m_axis_tdata[2*CW+23:2*CW+16]);
					check_field("visible", want.visible, m_axis_tuser);
					check_field("last", want.last, m_axis_tlast);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == OP_START)
					load_line(coord_t'(s_axis_tdata[CW-1:0]),
						coord_t'(s_axis_tdata[2*CW-1:CW]),
						coord_t'(s_axis_tdata[3*CW-1:2*CW]),
						coord_t'(s_axis_tdata[4*CW-1:3*CW]),
						color_t'({s_axis_tdata[4*CW+7:4*CW],
							s_axis_tdata[4*CW+15:4*CW+8],
							s_axis_tdata[4*CW+23:4*CW+16]}));
				else if (line_on)
					pending_pixels.push_back(emit_pixel());
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_CLIP_LEFT:   clip_left_q = cfg_data;
					REG_CLIP_RIGHT:  clip_right_q = cfg_data;
					REG_CLIP_TOP:    clip_top_q = cfg_data;
					REG_CLIP_BOTTOM: clip_bottom_q = cfg_data;
					default: ;
				endcase
			end
			outstanding <= pending_pixels.size();
		end
	end

endmodule

// ===== verif/clipped_line_rasterizer_core_tb.sv =====
// Stimulus, clock, reset and verdict for the clipped line rasterizer core.
`timescale 1ns / 1ps

module clipped_line_rasterizer_core_tb;
	import clr_pkg::*;

	// The receiver's long hold-off, long enough for the core to fill up and stall.
	localparam int HOLD_CYCLES = 200;
	// Cycles with no transaction on any channel before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;
	// Pause after the last expected pixel: a trailing step that the core ignores
	// may still sit in its input register.
	localparam int SETTLE_CYCLES = 6;
	localparam int TAIL_CYCLES = 20;
	localparam int ITEM_TARGET = 1700;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// Fields from bit 0 up: start_x, start_y, end_x, end_y, red, green, blue.
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// Field: opcode.
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// Fields from bit 0 up: pixel_x, pixel_y, out_red, out_green, out_blue.
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// Field: visible.
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CLIP_W-1:0]     cfg_data = '0;

	int mismatches;
	int outstanding;

	// Shared between the sender and the receiver: burst_mode turns idling off on
	// both sides, and each increment of hold_requests asks for one long hold-off.
	logic burst_mode = 1'b0;
	int   hold_requests = 0;
	int   items_done = 0;

	wire any_transaction = (s_axis_tvalid && s_axis_tready) ||
		(m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	clipped_line_rasterizer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	clipped_line_rasterizer_core_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	function automatic int line_span(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
		int dx, dy;
		dx = int'(x1) - int'(x0);
		dy = int'(y1) - int'(y0);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return (dx >= dy) ? dx : dy;
	endfunction

	// Offsets a coordinate by up to reach either way, folding back instead of
	// wrapping past the ends of the coordinate range.
	function automatic coord_t near(coord_t base, int reach);
		int d, v;
		d = int'($urandom_range(0, 2 * reach)) - reach;
		v = int'(base) + d;
		if (v > 32767 || v < -32768) v = int'(base) - d;
		return coord_t'(v);
	endfunction

	// One transaction on the input stream. When no gap is drawn, tvalid simply
	// stays high from the previous transaction.
	task automatic send_item(opcode_t op, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
			color_t rgb);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {rgb.blue, rgb.green, rgb.red, y1, x1, y0, x0};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Step transactions carry random endpoint and color bits, which the core
	// must ignore.
	task automatic send_step();
		send_item(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), color_t'($urandom));
	endtask

	// A start followed by a number of steps. Fewer steps than pixels leaves the
	// line to be abandoned by the next start; more steps run past its end.
	task automatic send_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1, color_t rgb,
			int steps);
		int pixels;
		pixels = line_span(x0, y0, x1, y1) + 1;
		send_item(OP_START, x0, y0, x1, y1, rgb);
		for (int i = 0; i < steps; i++) send_step();
		items_done += 1 + ((steps < pixels) ? steps : pixels);
	endtask

	// Stops offering input and waits until every predicted pixel has come out.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_clip(cfg_reg_t idx, clip_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_clip_rect(clip_t left, clip_t right, clip_t top, clip_t bottom);
		quiesce();
		write_clip(REG_CLIP_LEFT, left);
		write_clip(REG_CLIP_RIGHT, right);
		write_clip(REG_CLIP_TOP, top);
		write_clip(REG_CLIP_BOTTOM, bottom);
		cfg_valid <= 1'b0;
	endtask

	// The first six phases walk through each special rectangle once; later
	// phases pick any kind, most often a rectangle around the area where short lines are drawn.
	task automatic pick_clip_rect(int phase);
		int mode;
		clip_t a, b;
		mode = (phase < 6) ? phase : $urandom_range(0, 9);
		a = clip_t'($urandom_range(0, 120));
		b = clip_t'($urandom_range(0, 120));
		case (mode)
			0: set_clip_rect(0, 32767, 0, 32767);
			1: set_clip_rect(a + 60, a, b, b + 40);         // empty, left past right
			2: set_clip_rect(a, a + 1, b + 40, b);          // empty, top past bottom
			3: set_clip_rect(a, a, b, b);                   // a single pixel
			4: set_clip_rect(clip_t'($urandom), clip_t'($urandom), clip_t'($urandom),
				clip_t'($urandom));
			5: set_clip_rect(0, 0, 0, 0);
			default: set_clip_rect(a, a + clip_t'($urandom_range(0, 150)),
				b, b + clip_t'($urandom_range(0, 150)));
		endcase
	endtask

	task automatic random_line();
		coord_t x0, y0, x1, y1;
		int kind, reach, span, steps;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// Endpoints anywhere: long lines, only the first pixels are walked.
			x0 = coord_t'($urandom);
			y0 = coord_t'($urandom);
			x1 = coord_t'($urandom);
			y1 = coord_t'($urandom);
		end else begin
			if ($urandom_range(0, 3) != 0) begin
				x0 = coord_t'(int'($urandom_range(0, 360)) - 30);
				y0 = coord_t'(int'($urandom_range(0, 360)) - 30);
			end else begin
				x0 = coord_t'($urandom);
				y0 = coord_t'($urandom);
			end
			reach = ($urandom_range(0, 7) == 0) ? 40 : 12;
			x1 = near(x0, reach);
			y1 = near(y0, reach);
			case ($urandom_range(0, 7))
				0: x1 = x0;
				1: y1 = y0;
				2: begin
					x1 = x0;
					y1 = y0;
				end
				default: ;
			endcase
		end
		span = line_span(x0, y0, x1, y1);
		if (kind == 0)
			steps = $urandom_range(1, 6);
		else if ($urandom_range(0, 7) == 0)
			steps = $urandom_range(0, span);
		else
			steps = span + 1 + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
		send_line(x0, y0, x1, y1, color_t'($urandom), steps);
	endtask

	// Result side: a random wait before each pixel, plus a long hold-off
	// whenever the stimulus asks for one.
	initial begin : pixel_sink
		int gap;
		int holds_done;
		holds_done = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holds_done != hold_requests) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = burst_mode ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Ends a hung run: counts cycles in which no transaction completes anywhere.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || any_transaction) quiet = 0;
			else quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int phase;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the clip rectangle still at reset only the origin is visible: a
		// single-point line there, then a step with no line active.
		send_line(0, 0, 0, 0, 24'hff00ff, 2);

		set_clip_rect(0, 32767, 0, 32767);
		// Horizontal and vertical lines drawn backwards.
		send_line(5, 3, 2, 3, 24'hffffff, 4);
		send_line(4, 6, 4, 3, 24'h000000, 4);
		// Shallow line whose error lands exactly on the threshold.
		send_line(0, 0, 4, 2, 24'h00ff00, 5);
		// Full-range diagonal, abandoned after two pixels by the next start.
		send_line(-32768, 32767, 32767, -32768, 24'h0000ff, 2);
		// Steep line with x counting down, abandoned as the random part begins.
		send_line(3, -1, 1, 5, 24'hff0000, 3);

		phase = 0;
		while (items_done < ITEM_TARGET) begin
			pick_clip_rect(phase);
			burst_mode <= ($urandom_range(0, 3) == 0);
			// Hold the results back while lines keep coming, so the core stalls.
			if (phase == 2 || phase == 9) hold_requests++;
			repeat ($urandom_range(6, 14)) random_line();
			phase++;
		end

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
